// ----- design/rtdc_pkg.sv -----
`timescale 1ns / 1ps
// Package for the ray / triangle interval clip: payload structs, widths and
// the flags that pass between the pipeline parts. No dependencies.
package rtdc_pkg;

  localparam int CoordBits = 32;
  localparam int FracBits  = 16;
  localparam int DiffBits  = CoordBits + 1;
  localparam int ProdBits  = 2 * DiffBits;
  localparam int AbBits    = ProdBits + 1;
  localparam int MagBits   = AbBits - 1;
  localparam int RemBits   = MagBits + CoordBits;

  typedef struct packed {
    logic signed [CoordBits-1:0] org_x;
    logic signed [CoordBits-1:0] org_y;
    logic signed [CoordBits-1:0] dir_x;
    logic signed [CoordBits-1:0] dir_y;
    logic        [CoordBits-2:0] max_range;
    logic signed [CoordBits-1:0] ax;
    logic signed [CoordBits-1:0] ay;
    logic signed [CoordBits-1:0] bx;
    logic signed [CoordBits-1:0] by_coord;
    logic signed [CoordBits-1:0] cx;
    logic signed [CoordBits-1:0] cy;
  } rtdc_in_t;

  typedef struct packed {
    logic                        hit_valid;
    logic signed [CoordBits-1:0] clip_low;
    logic signed [CoordBits-1:0] clip_high;
  } rtdc_out_t;

  // Raw edge numerator and denominator, plus the orientation flip.
  typedef struct packed {
    logic signed [AbBits-1:0] a;
    logic signed [AbBits-1:0] b;
    logic                     flip;
  } rtdc_ab_t;

  // Edge class after orientation: denominator zero / positive, numerator negative.
  typedef struct packed {
    logic bzero;
    logic bpos;
    logic aneg;
  } rtdc_flag_t;

endpackage

// ----- design/rtdc_setup.sv -----
`timescale 1ns / 1ps
// Front end: edge differences, cross products and edge numerators/denominators.
// Three register stages. Depends on rtdc_pkg.
module rtdc_setup import rtdc_pkg::*; (
  input  logic     clk_i,
  input  rtdc_in_t in_i,
  output rtdc_ab_t ab_o [3]
);

  logic signed [CoordBits-1:0] vx [3];
  logic signed [CoordBits-1:0] vy [3];
  logic signed [CoordBits-1:0] wx [3];
  logic signed [CoordBits-1:0] wy [3];

  always_comb begin
    vx[0] = in_i.ax;
    vy[0] = in_i.ay;
    vx[1] = in_i.bx;
    vy[1] = in_i.by_coord;
    vx[2] = in_i.cx;
    vy[2] = in_i.cy;
    wx[0] = in_i.bx;
    wy[0] = in_i.by_coord;
    wx[1] = in_i.cx;
    wy[1] = in_i.cy;
    wx[2] = in_i.ax;
    wy[2] = in_i.ay;
  end

  logic signed [DiffBits-1:0] ex_q [3];
  logic signed [DiffBits-1:0] ey_q [3];
  logic signed [DiffBits-1:0] pvx_q [3];
  logic signed [DiffBits-1:0] pvy_q [3];
  logic signed [DiffBits-1:0] cax_q, cay_q, dx_q, dy_q;

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      ex_q[k]  <= DiffBits'(wx[k]) - DiffBits'(vx[k]);
      ey_q[k]  <= DiffBits'(wy[k]) - DiffBits'(vy[k]);
      pvx_q[k] <= DiffBits'(in_i.org_x) - DiffBits'(vx[k]);
      pvy_q[k] <= DiffBits'(in_i.org_y) - DiffBits'(vy[k]);
    end
    cax_q <= DiffBits'(in_i.cx) - DiffBits'(in_i.ax);
    cay_q <= DiffBits'(in_i.cy) - DiffBits'(in_i.ay);
    dx_q  <= DiffBits'(in_i.dir_x);
    dy_q  <= DiffBits'(in_i.dir_y);
  end

  logic signed [ProdBits-1:0] pa_q [3];
  logic signed [ProdBits-1:0] pb_q [3];
  logic signed [ProdBits-1:0] pc_q [3];
  logic signed [ProdBits-1:0] pd_q [3];
  logic signed [ProdBits-1:0] ar1_q, ar2_q;

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      pa_q[k] <= ex_q[k] * pvy_q[k];
      pb_q[k] <= ey_q[k] * pvx_q[k];
      pc_q[k] <= ex_q[k] * dy_q;
      pd_q[k] <= ey_q[k] * dx_q;
    end
    ar1_q <= ex_q[0] * cay_q;
    ar2_q <= ey_q[0] * cax_q;
  end

  logic signed [AbBits-1:0] area;
  rtdc_ab_t                 ab_q [3];

  assign area = AbBits'(ar1_q) - AbBits'(ar2_q);

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      ab_q[k].a    <= AbBits'(pa_q[k]) - AbBits'(pb_q[k]);
      ab_q[k].b    <= AbBits'(pc_q[k]) - AbBits'(pd_q[k]);
      // zero area orients like a negative one
      ab_q[k].flip <= area[AbBits-1] | (area == '0);
    end
  end

  assign ab_o = ab_q;

endmodule

// ----- design/rtdc_div.sv -----
`timescale 1ns / 1ps
// Pipelined restoring divider for one edge: q = -a/b in fixed point,
// truncated and saturated, one quotient bit per stage. Depends on rtdc_pkg.
module rtdc_div import rtdc_pkg::*; #(
  parameter int FRAC_BITS = FracBits
) (
  input  logic                        clk_i,
  input  rtdc_ab_t                    ab_i,
  output logic signed [CoordBits-1:0] q_o,
  output rtdc_flag_t                  flag_o
);

  localparam logic signed [CoordBits-1:0] QMax = {1'b0, {(CoordBits-1){1'b1}}};
  localparam logic signed [CoordBits-1:0] QMin = {1'b1, {(CoordBits-1){1'b0}}};

  // magnitudes and classes
  logic               an, bn, az, bz;
  logic [RemBits-1:0] n_q;
  logic [MagBits-1:0] d_q;
  logic               neg1_q;
  rtdc_flag_t         flag1_q;

  assign an = ab_i.a[AbBits-1];
  assign bn = ab_i.b[AbBits-1];
  assign az = (ab_i.a == '0);
  assign bz = (ab_i.b == '0);

  always_ff @(posedge clk_i) begin
    n_q <= RemBits'(an ? MagBits'(-ab_i.a) : MagBits'(ab_i.a)) << FRAC_BITS;
    d_q <= bn ? MagBits'(-ab_i.b) : MagBits'(ab_i.b);
    neg1_q        <= (an == bn);
    flag1_q.bzero <= bz;
    flag1_q.bpos  <= ab_i.flip ? bn : (!bn && !bz);
    flag1_q.aneg  <= ab_i.flip ? (!an && !az) : an;
  end

  logic [RemBits-1:0]   rem_q  [CoordBits];
  logic [MagBits-1:0]   dd_q   [CoordBits];
  logic [CoordBits-1:0] quo_q  [CoordBits+1];
  logic                 sat_q  [CoordBits+1];
  logic                 neg_q  [CoordBits+1];
  rtdc_flag_t           flg_q  [CoordBits+1];

  // overflow when the quotient would need more than CoordBits bits
  always_ff @(posedge clk_i) begin
    rem_q[0] <= n_q;
    dd_q[0]  <= d_q;
    quo_q[0] <= '0;
    sat_q[0] <= n_q >= (RemBits'(d_q) << CoordBits);
    neg_q[0] <= neg1_q;
    flg_q[0] <= flag1_q;
  end

  for (genvar k = 0; k < CoordBits; k++) begin : g_bit
    localparam int Sh = CoordBits - 1 - k;
    logic [RemBits-1:0] trial;
    logic               ge;

    assign trial = RemBits'(dd_q[k]) << Sh;
    assign ge    = rem_q[k] >= trial;

    always_ff @(posedge clk_i) begin
      quo_q[k+1] <= {quo_q[k][CoordBits-2:0], ge};
      sat_q[k+1] <= sat_q[k];
      neg_q[k+1] <= neg_q[k];
      flg_q[k+1] <= flg_q[k];
    end

    if (k < CoordBits - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        rem_q[k+1] <= ge ? rem_q[k] - trial : rem_q[k];
        dd_q[k+1]  <= dd_q[k];
      end
    end
  end

  logic [CoordBits-1:0] qf;
  logic                 big;

  assign qf  = quo_q[CoordBits];
  assign big = sat_q[CoordBits] | qf[CoordBits-1];

  always_ff @(posedge clk_i) begin
    if (big) begin
      q_o <= neg_q[CoordBits] ? QMin : QMax;
    end else begin
      q_o <= neg_q[CoordBits] ? -$signed(qf) : $signed(qf);
    end
    flag_o <= flg_q[CoordBits];
  end

endmodule

// ----- design/rtdc_merge.sv -----
`timescale 1ns / 1ps
// Interval merge: folds the edge quotients of the triangle into [low, high] and
// decides the hit from registered partial bounds and registers the result. Depends on rtdc_pkg.
module rtdc_merge import rtdc_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic        [CoordBits-2:0] range_i,
  input  logic signed [CoordBits-1:0] q_i    [3],
  input  rtdc_flag_t                  flag_i [3],
  output logic                        valid_o,
  output rtdc_out_t                   res_o
);

  logic signed [CoordBits-1:0] rng;
  logic signed [CoordBits-1:0] lc [3];
  logic signed [CoordBits-1:0] hc [3];
  logic                        rej;

  assign rng = $signed({1'b0, range_i});

  always_comb begin
    rej = 1'b0;
    for (int k = 0; k < 3; k++) begin
      lc[k] = (flag_i[k].bpos && q_i[k] > 0) ? q_i[k] : '0;
      hc[k] = (!flag_i[k].bzero && !flag_i[k].bpos && q_i[k] < rng) ? q_i[k] : rng;
      rej   = rej | (flag_i[k].bzero & flag_i[k].aneg);
    end
  end

  logic                        v1_q, rej1_q;
  logic signed [CoordBits-1:0] lo01_q, hi01_q, lc2_q, hc2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    lo01_q <= (lc[1] > lc[0]) ? lc[1] : lc[0];
    hi01_q <= (hc[1] < hc[0]) ? hc[1] : hc[0];
    lc2_q  <= lc[2];
    hc2_q  <= hc[2];
    rej1_q <= rej;
  end

  logic signed [CoordBits-1:0] lo, hi;
  logic                        ok;

  assign lo = (lc2_q > lo01_q) ? lc2_q : lo01_q;
  assign hi = (hc2_q < hi01_q) ? hc2_q : hi01_q;
  assign ok = !rej1_q && (hi > lo);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= v1_q;
    end
  end

  // drop the interval of a rejected item
  always_ff @(posedge clk_i) begin
    res_o.hit_valid <= ok;
    res_o.clip_low  <= ok ? lo : '0;
    res_o.clip_high <= ok ? hi : '0;
  end

endmodule

// ----- design/ray_triangle_2d_clip.sv -----
`timescale 1ns / 1ps
// Top level of the ray / triangle interval clip.
// Depends on rtdc_pkg, rtdc_setup, rtdc_div and rtdc_merge.
//
// One item is taken in every clock cycle and busy_o stays low: the pipeline
// never stalls, since the receiver cannot hold results off. Each result
// appears on res_o with valid_o high for one cycle; the depth of the
// pipeline is set by the restoring dividers, which resolve one quotient bit
// per stage, with a divider for each edge side by side, plus the front-end
// stages for differences, products and edge terms, and the merge stages.
module ray_triangle_2d_clip import rtdc_pkg::*; #(
  parameter int FRAC_BITS = FracBits
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  rtdc_in_t  in_i,
  output logic      busy_o,
  output logic      valid_o,
  output rtdc_out_t res_o
);

  localparam int Lat = CoordBits + 6;

  rtdc_ab_t                    ab [3];
  logic signed [CoordBits-1:0] q [3];
  rtdc_flag_t                  flag [3];

  assign busy_o = 1'b0;

  rtdc_setup u_setup (
    .clk_i (clk_i),
    .in_i  (in_i),
    .ab_o  (ab)
  );

  for (genvar k = 0; k < 3; k++) begin : g_edge
    rtdc_div #(
      .FRAC_BITS (FRAC_BITS)
    ) u_div (
      .clk_i  (clk_i),
      .ab_i   (ab[k]),
      .q_o    (q[k]),
      .flag_o (flag[k])
    );
  end

  // valid and range travel alongside the arithmetic
  logic                 vld_q [Lat];
  logic [CoordBits-2:0] rng_q [Lat];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Lat; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else begin
      vld_q[0] <= start_i & ~busy_o;
      for (int i = 1; i < Lat; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rng_q[0] <= in_i.max_range;
    for (int i = 1; i < Lat; i++) begin
      rng_q[i] <= rng_q[i-1];
    end
  end

  rtdc_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld_q[Lat-1]),
    .range_i (rng_q[Lat-1]),
    .q_i     (q),
    .flag_i  (flag),
    .valid_o (valid_o),
    .res_o   (res_o)
  );

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// Testbench for ray_triangle_2d_clip: random and directed ray/triangle clips,
// predicted in 128-bit arithmetic and checked in order. Depends on rtdc_pkg.
module tb_top;
  import rtdc_pkg::*;

  typedef logic signed [127:0] wide_t;

  localparam int  CycleLimit = 400000;
  localparam int  DrainCycles = 60;
  localparam int  RandItems = 750;

  // Expected clip results, held in order of transfer.
  class clip_board;
    rtdc_out_t expected_q[$];
    int        errors;

    function automatic longint edge_quot(wide_t a, wide_t b);
      wide_t n, d, q;
      bit    neg;
      neg = (a < 0) == (b < 0);
      n = (a < 0) ? -a : a;
      n = n <<< FracBits;
      d = (b < 0) ? -b : b;
      if (n == 0) return 0;
      q = n / d;
      if (!neg) begin
        if (q > wide_t'(longint'(32'h7fffffff))) return 64'sd2147483647;
        return longint'(q);
      end
      if (q >= wide_t'(longint'(33'h080000000))) return -64'sd2147483648;
      return -longint'(q);
    endfunction

    function automatic rtdc_out_t clip_predict(rtdc_in_t it);
      wide_t     vx [3];
      wide_t     vy [3];
      wide_t     area, ex, ey, a, b;
      longint    lo, hi, q;
      bit        flip, ok;
      int        j;
      rtdc_out_t r;
      vx[0] = wide_t'(it.ax); vy[0] = wide_t'(it.ay);
      vx[1] = wide_t'(it.bx); vy[1] = wide_t'(it.by_coord);
      vx[2] = wide_t'(it.cx); vy[2] = wide_t'(it.cy);
      area = (vx[1] - vx[0]) * (vy[2] - vy[0]) - (vy[1] - vy[0]) * (vx[2] - vx[0]);
      flip = (area <= 0);
      lo = 0;
      hi = longint'(it.max_range);
      ok = 1'b1;
      for (int i = 0; i < 3 && ok; i++) begin
        j = (i + 1) % 3;
        ex = vx[j] - vx[i];
        ey = vy[j] - vy[i];
        a = ex * (wide_t'(it.org_y) - vy[i]) - ey * (wide_t'(it.org_x) - vx[i]);
        b = ex * wide_t'(it.dir_y) - ey * wide_t'(it.dir_x);
        if (flip) begin
          a = -a;
          b = -b;
        end
        if (b == 0) begin
          if (a < 0) ok = 1'b0;
        end else if (b > 0) begin
          q = edge_quot(a, b);
          if (q > lo) lo = q;
        end else begin
          q = edge_quot(a, b);
          if (q < hi) hi = q;
        end
        if (lo > hi) ok = 1'b0;
      end
      if (ok && !(hi > lo)) ok = 1'b0;
      r.hit_valid = ok;
      r.clip_low  = ok ? lo[31:0] : '0;
      r.clip_high = ok ? hi[31:0] : '0;
      return r;
    endfunction

    function void note_item(rtdc_in_t it);
      expected_q.insert(expected_q.size(), clip_predict(it));
    endfunction

    function void check_result(rtdc_out_t got);
      rtdc_out_t exp_r;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", got);
        return;
      end
      exp_r = expected_q.pop_front();
      if (got.hit_valid !== exp_r.hit_valid || got.clip_low !== exp_r.clip_low ||
          got.clip_high !== exp_r.clip_high) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected hit %0b low %0d high %0d, got hit %0b low %0d high %0d",
                   exp_r.hit_valid, exp_r.clip_low, exp_r.clip_high,
                   got.hit_valid, got.clip_low, got.clip_high);
      end
    endfunction
  endclass

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      start_i = 1'b0;
  rtdc_in_t  in_i = '0;
  logic      busy_o, valid_o;
  rtdc_out_t res_o;
  clip_board board = new();
  int        cycles = 0;
  bit        no_gaps = 1'b0;

  ray_triangle_2d_clip dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .in_i(in_i),
    .busy_o(busy_o), .valid_o(valid_o), .res_o(res_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("ray_triangle_2d_clip regression: fail");
      $finish;
    end
    if (rst_ni) begin
      if (start_i && !busy_o) board.note_item(in_i);
      if (valid_o) board.check_result(res_o);
    end
  end

  // Idle at random, then hold the item until its transfer.
  task automatic send_clip(rtdc_in_t it);
    while (!no_gaps && $urandom_range(0, 99) < 27) begin
      @(negedge clk_i);
      start_i = 1'b0;
    end
    @(negedge clk_i);
    start_i = 1'b1;
    in_i = it;
    do @(posedge clk_i); while (busy_o);
  endtask

  function automatic int small_coord();
    return int'($urandom_range(0, 400000)) - 200000;
  endfunction

  function automatic rtdc_in_t noise_item();
    rtdc_in_t          it;
    logic [11*32-1:0]  raw;
    raw = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
           $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
    it = raw[$bits(rtdc_in_t)-1:0];
    return it;
  endfunction

  // Triangle of moderate size; the ray is aimed near its centroid in half of the cases, else its direction is random.
  function automatic rtdc_in_t aimed_item();
    rtdc_in_t it;
    int gx, gy;
    it.ax = small_coord(); it.ay = small_coord();
    it.bx = small_coord(); it.by_coord = small_coord();
    it.cx = small_coord(); it.cy = small_coord();
    it.org_x = small_coord(); it.org_y = small_coord();
    gx = (it.ax + it.bx + it.cx) / 3 + int'($urandom_range(0, 2000)) - 1000;
    gy = (it.ay + it.by_coord + it.cy) / 3 + int'($urandom_range(0, 2000)) - 1000;
    case ($urandom_range(0, 3))
      0: begin it.dir_x = gx - it.org_x; it.dir_y = gy - it.org_y; end
      1: begin it.dir_x = (gx - it.org_x) >>> 8; it.dir_y = (gy - it.org_y) >>> 8; end
      2: begin it.dir_x = small_coord(); it.dir_y = small_coord(); end
      default: begin it.dir_x = $urandom(); it.dir_y = $urandom(); end
    endcase
    case ($urandom_range(0, 2))
      0: it.max_range = (CoordBits-1)'($urandom_range(0, 4 << FracBits));
      1: it.max_range = (CoordBits-1)'($urandom_range(0, 1000));
      default: it.max_range = (CoordBits-1)'($urandom());
    endcase
    if ($urandom_range(0, 9) == 0) begin
      it.cx = it.bx; it.cy = it.by_coord;
    end
    return it;
  endfunction

  initial begin
    rtdc_in_t it;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Extremes of every field.
    send_clip('0);
    send_clip('1);
    it = '0;
    it.org_x = 32'sh80000000; it.org_y = 32'sh7fffffff;
    it.dir_x = 32'sh7fffffff; it.dir_y = 32'sh80000000;
    it.max_range = '1;
    it.ax = 32'sh80000000; it.ay = 32'sh80000000;
    it.bx = 32'sh7fffffff; it.by_coord = 32'sh80000000;
    it.cx = 32'sh80000000; it.cy = 32'sh7fffffff;
    send_clip(it);
    it.ay = 32'sh7fffffff; it.by_coord = 32'sh7fffffff; it.cy = 32'sh80000000;
    send_clip(it);
    // Counter-clockwise right triangle with legs of four units, ray crossing it along x.
    it = '0;
    it.ax = 0; it.ay = 0; it.bx = 4 << 16; it.by_coord = 0; it.cx = 0; it.cy = 4 << 16;
    it.org_x = -(1 << 16); it.org_y = 1 << 16; it.dir_x = 1 << 16;
    it.max_range = (CoordBits-1)'(10 << 16);
    send_clip(it);
    // Same triangle clockwise: orientation flips the edge tests.
    it.bx = 0; it.by_coord = 4 << 16; it.cx = 4 << 16; it.cy = 0;
    send_clip(it);
    // Zero area triangle.
    it.cx = 0; it.cy = 2 << 16;
    send_clip(it);
    // Ray parallel to an edge, inside and outside its half-plane.
    it.bx = 4 << 16; it.by_coord = 0; it.cx = 0; it.cy = 4 << 16;
    it.org_x = 1 << 16; it.org_y = 1 << 16; it.dir_x = 1 << 16; it.dir_y = 0;
    send_clip(it);
    it.org_y = -(1 << 16);
    send_clip(it);
    // Zero direction: every edge parallel.
    it.dir_x = 0; it.org_y = 1 << 16;
    send_clip(it);
    // Tiny direction, large distance: quotient saturates.
    it.org_x = -32'sh40000000; it.dir_x = 1;
    send_clip(it);
    it.dir_x = -1;
    send_clip(it);
    // Zero range: empty interval.
    it.dir_x = 1 << 16; it.org_x = 1 << 16; it.max_range = '0;
    send_clip(it);
    // Ray ends exactly on entry edge.
    it.org_x = -(1 << 16); it.max_range = (CoordBits-1)'(1 << 16);
    send_clip(it);

    for (int n = 0; n < RandItems; n++) begin
      no_gaps = (n >= 250 && n < 400);
      if ($urandom_range(0, 99) < 20) send_clip(noise_item());
      else send_clip(aimed_item());
    end
    @(negedge clk_i);
    start_i = 1'b0;

    while (board.expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (board.errors == 0 && board.expected_q.size() == 0)
      $display("ray_triangle_2d_clip regression: pass");
    else
      $display("ray_triangle_2d_clip regression: fail");
    $finish;
  end
endmodule
